/* hdl/pms_pkg.sv */
// Package with the shared constants and types of the minimum spanning tree block.
`timescale 1ns / 1ps
package pms_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int WEIGHT_BITS  = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int KEY_W        = WEIGHT_BITS + 1;
    localparam logic [KEY_W-1:0] KEY_INF = KEY_W'(1) << WEIGHT_BITS;

    // Cycles for a candidate to ripple from the first cell to the tail register.
    localparam int SETTLE = MAX_VERTICES + 1;
    localparam int CNT_W  = $clog2(SETTLE + 1);

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic                   clear;
        logic                   wr_en;
        logic [VIDX_W-1:0]      wr_a;
        logic [VIDX_W-1:0]      wr_b;
        logic [WEIGHT_BITS-1:0] wr_w;
        logic                   upd;
        logic [VIDX_W-1:0]      sel_u;
        logic [VCNT_W-1:0]      n;
    } ctrl_t;

    // Best candidate seen so far along the chain.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VIDX_W-1:0] idx;
    } cand_t;

    // Per-vertex result state read out during emission.
    typedef struct packed {
        logic              visited;
        logic [KEY_W-1:0]  key;
        logic [VIDX_W-1:0] parent;
    } status_t;

endpackage

/* hdl/prim_minimum_spanning_tree.sv */
// Top level of the Prim minimum spanning tree block: controller, cell row and result register.
//
// Edges arrive as beats on the s_ channel, one per cycle, and are written into
// the adjacency columns held by a row of vertex cells. The beat with s_tlast
// set ends the graph (its edge, if any, is written first) and starts the tree
// search from vertex 0; s_tready stays low until the tree has been emitted and the cells cleared.
// Each round lets the least-key candidate ripple through the cell row, one
// cell per cycle, and then broadcasts the winner so every cell relaxes its key
// in the same cycle. The search runs up to vertex_count rounds and stops
// early when no unvisited vertex can be reached.
// Results follow on the m_ channel, one beat per vertex 1 .. vertex_count-1 in
// index order, with m_tlast on the final one; a stalled receiver simply holds
// the output register and pauses the emission. A clearing state then wipes the cell
// state, after which new edges are taken even while the last beat still waits.
// The vertex_count register is written through cfg_valid/cfg_ready; the user must write
// it only while the block is idle, which the block leaves unchecked. A value of 0 acts
// as 1 and values above MAX_VERTICES are clamped. Reset (aresetn low, synchronous)
// clears the graph, sets the count to 16 and empties the output register.
`timescale 1ns / 1ps
module prim_minimum_spanning_tree (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // from_vertex[3:0], to_vertex[7:4], edge_weight[23:8]
    input  logic        s_tuser,   // edge_valid
    input  logic        s_tlast,   // last_edge
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // vertex_low[3:0], vertex_high[7:4], tree_weight[23:8]
    output logic        m_tuser,   // reached
    output logic        m_tlast,   // last_result
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import pms_pkg::*;

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [4:0]        cfg_reg;
    logic [VCNT_W-1:0] n_reg, n_next, eff_n;
    logic [VCNT_W-1:0] round_reg, round_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VIDX_W-1:0] v_reg, v_next;
    logic              mv_reg, mv_next;
    logic [23:0]       md_reg, md_next;
    logic              mu_reg, mu_next;
    logic              ml_reg, ml_next;

    ctrl_t   ctrl;
    cand_t   chain [MAX_VERTICES+1];
    status_t stat [MAX_VERTICES];
    status_t sv;
    logic    in_acc, last_v, load_out;
    logic [VIDX_W-1:0] lo, hi;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_LOAD);
    assign in_acc    = s_tvalid && s_tready;

    always_comb begin
        if (cfg_reg == '0) begin
            eff_n = VCNT_W'(1);
        end else if ({27'd0, cfg_reg} > 32'(MAX_VERTICES)) begin
            eff_n = VCNT_W'(MAX_VERTICES);
        end else begin
            eff_n = VCNT_W'(cfg_reg);
        end
    end

    assign chain[0] = '{key: KEY_INF, idx: '0};

    genvar g;
    generate
        for (g = 0; g < MAX_VERTICES; g++) begin : g_cell
            pms_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (VIDX_W'(g)),
                .ctrl     (ctrl),
                .cand_in  (chain[g]),
                .cand_out (chain[g+1]),
                .status   (stat[g])
            );
        end
    endgenerate

    // Result of the vertex being emitted: endpoints ordered, zeros if unreached.
    assign sv     = stat[v_reg];
    assign lo     = (sv.parent < v_reg) ? sv.parent : v_reg;
    assign hi     = (sv.parent < v_reg) ? v_reg : sv.parent;
    assign last_v = (VCNT_W'(v_reg) == n_reg - VCNT_W'(1));
    assign load_out = (state_reg == ST_EMIT) && (!mv_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        round_next = round_reg;
        cnt_next   = cnt_reg;
        v_next     = v_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        mu_next    = mu_reg;
        ml_next    = ml_reg;

        ctrl       = '0;
        ctrl.n     = n_reg;
        ctrl.wr_a  = VIDX_W'(s_tdata[3:0]);
        ctrl.wr_b  = VIDX_W'(s_tdata[7:4]);
        ctrl.wr_w  = WEIGHT_BITS'(s_tdata[23:8]);
        ctrl.sel_u = chain[MAX_VERTICES].idx;
        ctrl.wr_en = in_acc && s_tuser
                     && ({28'd0, s_tdata[3:0]} < 32'(MAX_VERTICES))
                     && ({28'd0, s_tdata[7:4]} < 32'(MAX_VERTICES));

        case (state_reg)
            ST_LOAD: begin
                if (in_acc && s_tlast) begin
                    n_next     = eff_n;
                    round_next = '0;
                    cnt_next   = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (cnt_reg == CNT_W'(SETTLE)) begin
                    cnt_next = '0;
                    if (chain[MAX_VERTICES].key >= KEY_INF) begin
                        v_next     = VIDX_W'(1);
                        state_next = (n_reg == VCNT_W'(1)) ? ST_DONE : ST_EMIT;
                    end else begin
                        ctrl.upd   = 1'b1;
                        round_next = round_reg + 1'b1;
                        if (round_next == n_reg) begin
                            v_next     = VIDX_W'(1);
                            state_next = (n_reg == VCNT_W'(1)) ? ST_DONE : ST_EMIT;
                        end
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (load_out) begin
                    mv_next = 1'b1;
                    mu_next = sv.visited;
                    ml_next = last_v;
                    if (sv.visited) begin
                        md_next = {16'(sv.key), 4'(hi), 4'(lo)};
                    end else begin
                        md_next = '0;
                    end
                    if (last_v) begin
                        state_next = ST_DONE;
                    end else begin
                        v_next = v_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                ctrl.clear = 1'b1;
                state_next = ST_LOAD;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cfg_reg   <= 5'd16;
            n_reg     <= VCNT_W'(1);
            round_reg <= '0;
            cnt_reg   <= '0;
            v_reg     <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_data;
            end
            n_reg     <= n_next;
            round_reg <= round_next;
            cnt_reg   <= cnt_next;
            v_reg     <= v_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        md_reg <= md_next;
        mu_reg <= mu_next;
        ml_reg <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

endmodule

/* hdl/pms_cell.sv */
// One vertex cell: its adjacency column, key, parent and a stage of the min chain.
`timescale 1ns / 1ps
module pms_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [pms_pkg::VIDX_W-1:0] cell_idx,
    input  pms_pkg::ctrl_t            ctrl,
    input  pms_pkg::cand_t            cand_in,
    output pms_pkg::cand_t            cand_out,
    output pms_pkg::status_t          status
);
    import pms_pkg::*;

    logic [WEIGHT_BITS-1:0] col_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] colv_reg;
    logic                   visited_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [VIDX_W-1:0]      parent_reg;
    cand_t                  cand_reg;

    logic [WEIGHT_BITS-1:0] adj_u;
    logic                   active;

    // Weight toward the vertex chosen this round; an entry never written reads zero.
    assign adj_u  = colv_reg[ctrl.sel_u] ? col_reg[ctrl.sel_u] : '0;
    assign active = ({{(32-VIDX_W){1'b0}}, cell_idx} < 32'(ctrl.n)) && !visited_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && cell_idx == ctrl.wr_b) begin
            col_reg[ctrl.wr_a] <= ctrl.wr_w;
        end else if (ctrl.wr_en && cell_idx == ctrl.wr_a) begin
            col_reg[ctrl.wr_b] <= ctrl.wr_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            colv_reg    <= '0;
            visited_reg <= 1'b0;
            key_reg     <= (cell_idx == '0) ? '0 : KEY_INF;
            parent_reg  <= '0;
            cand_reg    <= '{key: KEY_INF, idx: '0};
        end else begin
            if (ctrl.wr_en && cell_idx == ctrl.wr_b) begin
                colv_reg[ctrl.wr_a] <= 1'b1;
            end else if (ctrl.wr_en && cell_idx == ctrl.wr_a) begin
                colv_reg[ctrl.wr_b] <= 1'b1;
            end
            if (ctrl.upd) begin
                if (cell_idx == ctrl.sel_u) begin
                    visited_reg <= 1'b1;
                end else if (active && adj_u != '0 && {1'b0, adj_u} < key_reg) begin
                    key_reg    <= {1'b0, adj_u};
                    parent_reg <= ctrl.sel_u;
                end
            end
            // Strict compare keeps the lower index from upstream on a tie.
            if (active && key_reg < cand_in.key) begin
                cand_reg <= '{key: key_reg, idx: cell_idx};
            end else begin
                cand_reg <= cand_in;
            end
        end
    end

    assign cand_out = cand_reg;
    assign status   = '{visited: visited_reg, key: key_reg, parent: parent_reg};

endmodule

/* hdl/pms_checker.sv */
// Port-level checker for the minimum spanning tree block and its bind statement.
`timescale 1ns / 1ps
module pms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result beat stays valid and keeps its data and last flag.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Once the last edge of a graph is taken, the input is closed.
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open after last edge");

    // An unreached vertex carries no edge.
    a_unreached: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 24'd0)
        else $error("unreached vertex with nonzero edge");

    // A tree edge has two distinct endpoints in order.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[3:0] < m_tdata[7:4])
        else $error("tree edge endpoints out of order");

endmodule

bind prim_minimum_spanning_tree pms_checker u_pms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/sv/mst_checker.sv */
// Checker for the spanning tree block: watches the channels, predicts tree edges and compares.
`timescale 1ns / 1ps
module mst_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // from_vertex[3:0], to_vertex[7:4], edge_weight[23:8]
    input  logic        s_tuser,   // edge_valid
    input  logic        s_tlast,   // last_edge
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // vertex_low[3:0], vertex_high[7:4], tree_weight[23:8]
    input  logic        m_tuser,   // reached
    input  logic        m_tlast,   // last_result
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    output int          fail_count,
    output int          pending_edges
);
    import pms_pkg::*;

    typedef struct packed {
        logic [3:0]  lo;
        logic [3:0]  hi;
        logic [15:0] w;
        logic        reached;
        logic        last;
    } tree_edge_t;

    logic [15:0] adj [MAX_VERTICES][MAX_VERTICES];
    logic [4:0]  count_reg;
    tree_edge_t  tree_q[$];

    task automatic solve_tree();
        int n;
        logic              seen [MAX_VERTICES];
        logic [KEY_W-1:0]  key  [MAX_VERTICES];
        logic [3:0]        par  [MAX_VERTICES];
        int u;
        tree_edge_t e;
        n = (count_reg == 0) ? 1 : (count_reg > MAX_VERTICES) ? MAX_VERTICES : count_reg;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            seen[i] = 0;
            key[i] = KEY_INF;
            par[i] = 0;
        end
        key[0] = 0;
        for (int r = 0; r < n; r++) begin
            u = n;
            for (int i = 0; i < n; i++)
                if (!seen[i] && (u == n || key[i] < key[u])) u = i;
            if (u == n || key[u] >= KEY_INF) break;
            seen[u] = 1;
            for (int j = 0; j < n; j++)
                if (adj[u][j] != 0 && !seen[j] && {1'b0, adj[u][j]} < key[j]) begin
                    key[j] = {1'b0, adj[u][j]};
                    par[j] = u[3:0];
                end
        end
        for (int v = 1; v < n; v++) begin
            if (seen[v]) begin
                e.lo = (par[v] < v) ? par[v] : v[3:0];
                e.hi = (par[v] < v) ? v[3:0] : par[v];
                e.w = key[v][15:0];
                e.reached = 1;
            end else begin
                e = '0;
            end
            e.last = (v == n - 1);
            tree_q.push_back(e);
        end
        foreach (adj[i, j]) adj[i][j] = '0;
    endtask

    always @(posedge aclk) begin
        tree_edge_t exp_e;
        int errs;
        errs = 0;
        if (!aresetn) begin
            count_reg <= 5'd16;
            foreach (adj[i, j]) adj[i][j] = '0;
            tree_q.delete();
            fail_count <= 0;
            pending_edges <= 0;
        end else begin
            if (cfg_valid && cfg_ready) count_reg <= cfg_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    adj[s_tdata[3:0]][s_tdata[7:4]] = s_tdata[23:8];
                    adj[s_tdata[7:4]][s_tdata[3:0]] = s_tdata[23:8];
                end
                if (s_tlast) solve_tree();
            end
            if (m_tvalid && m_tready) begin
                if (tree_q.size() == 0) begin
                    $error("unexpected result beat %h", m_tdata);
                    errs++;
                end else begin
                    exp_e = tree_q.pop_front();
                    if (m_tdata[3:0] !== exp_e.lo) begin
                        $error("vertex_low exp %0d got %0d", exp_e.lo, m_tdata[3:0]);
                        errs++;
                    end
                    if (m_tdata[7:4] !== exp_e.hi) begin
                        $error("vertex_high exp %0d got %0d", exp_e.hi, m_tdata[7:4]);
                        errs++;
                    end
                    if (m_tdata[23:8] !== exp_e.w) begin
                        $error("tree_weight exp %0d got %0d", exp_e.w, m_tdata[23:8]);
                        errs++;
                    end
                    if (m_tuser !== exp_e.reached) begin
                        $error("reached exp %0d got %0d", exp_e.reached, m_tuser);
                        errs++;
                    end
                    if (m_tlast !== exp_e.last) begin
                        $error("last_result exp %0d got %0d", exp_e.last, m_tlast);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
            pending_edges <= tree_q.size();
        end
    end
endmodule

/* tb/sv/tb.sv */
// Testbench top for the spanning tree block: stimulus, stalls and the verdict.
`timescale 1ns / 1ps
module tb;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    int          fail_count;
    int          pending_edges;
    int          cycle_no = 0;
    logic        stall_req = 0;  // asks the receiver for a long stall
    int          hold_off = 0;   // cycles left in the long receiver stall
    int          edges_sent = 0;
    int          graph_n = 16;   // vertex count currently in force

    always #5 aclk = ~aclk;

    prim_minimum_spanning_tree DUT (.*);

    mst_checker checker_i (.*);

    // Hard limit: about 350 beats and some 40 graphs, with their compute time and
    // stalls on both sides, stay far below this.
    localparam int CYCLE_LIMIT = 400000;
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random ready, plus a long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
            hold_off <= 0;
        end else if (stall_req) begin
            hold_off <= 600;
            m_tready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(0, 99) < 70);
        end
    end

    // Send one beat, then wait a random gap with tvalid low.
    task automatic send_edge(input logic [3:0] a, input logic [3:0] b,
                             input logic [15:0] w, input logic ev, input logic lst);
        int g;
        s_tvalid <= 1;
        s_tdata  <= {w, b, a};
        s_tuser  <= ev;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        edges_sent++;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Let the block go quiet, then write the vertex count.
    task automatic set_count(input logic [4:0] c);
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_edges != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        cfg_valid <= 1;
        cfg_data  <= c;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        graph_n = (c == 0) ? 1 : (c > 16) ? 16 : c;
    endtask

    // A random graph: mostly edges among the live vertices, some noise.
    task automatic random_graph(input int n_edges);
        logic [3:0] a, b;
        logic [15:0] w;
        int top;
        top = graph_n - 1;
        for (int k = 0; k < n_edges; k++) begin
            if ($urandom_range(0, 9) < 8) begin
                a = 4'($urandom_range(0, top));
                b = 4'($urandom_range(0, top));
            end else begin
                a = 4'($urandom);
                b = 4'($urandom);
            end
            case ($urandom_range(0, 5))
                0: w = 16'($urandom);
                1: w = 0;
                2: w = 16'hFFFF;
                default: w = 16'($urandom_range(1, 20));
            endcase
            send_edge(a, b, w, $urandom_range(0, 9) != 0, k == n_edges - 1);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset count 16, extremes, ties, overwrite, self loop, zero weight.
        send_edge(4'd0, 4'd15, 16'hFFFF, 1, 0);
        send_edge(4'd0, 4'd1, 16'd5, 1, 0);
        send_edge(4'd1, 4'd0, 16'd3, 1, 0);      // overwrite
        send_edge(4'd0, 4'd2, 16'd3, 1, 0);      // tie with vertex 1
        send_edge(4'd2, 4'd2, 16'd1, 1, 0);      // self loop
        send_edge(4'd2, 4'd3, 16'd0, 1, 0);      // zero weight: no edge
        send_edge(4'd1, 4'd3, 16'd7, 0, 0);      // not an edge
        send_edge(4'd14, 4'd15, 16'd1, 1, 0);
        send_edge(4'd15, 4'd3, 16'h8000, 1, 1);  // edge on the last beat
        send_edge(4'd0, 4'd0, 16'd0, 0, 1);      // empty graph: all unreachable

        set_count(5'd1);                          // single vertex: no results
        send_edge(4'd0, 4'd1, 16'd2, 1, 1);
        set_count(5'd0);
        send_edge(4'd0, 4'd0, 16'd0, 0, 1);
        set_count(5'd31);                         // clamps to 16
        send_edge(4'd5, 4'd6, 16'd9, 1, 0);
        send_edge(4'd0, 4'd5, 16'd4, 1, 1);
        set_count(5'd2);
        send_edge(4'd1, 4'd0, 16'h00FF, 1, 1);

        // Pressure: a long receiver stall while three graphs at the full vertex count are offered.
        set_count(5'd16);
        stall_req <= 1;
        @(posedge aclk);
        stall_req <= 0;
        for (int g = 0; g < 3; g++) random_graph(6);

        // Random graphs at varied counts.
        while (edges_sent < 340) begin
            if ($urandom_range(0, 3) == 0)
                set_count($urandom_range(0, 9) == 0 ? 5'($urandom) : 5'($urandom_range(2, 8)));
            random_graph($urandom_range(1, 2 * graph_n + 2));
        end

        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_edges != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* sim.f */
hdl/pms_pkg.sv
hdl/pms_cell.sv
hdl/prim_minimum_spanning_tree.sv
hdl/pms_checker.sv
tb/sv/mst_checker.sv
tb/sv/tb.sv
